[rtl/bffa_pkg.sv]
// package for the bitmap first-fit allocator
// shared constants, codes and controller/datapath command types; no dependencies
`timescale 1ns / 1ps
package bffa_pkg;
	localparam int UNITS = 1024;
	localparam int UW = $clog2(UNITS);
	localparam int HEADER_BYTES = 8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] REG_UNIT_BYTES = 2'd0;
	localparam logic [1:0] REG_UNITS_IN_USE = 2'd1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV, S_SCAN, S_MARK, S_FRD, S_FCLR, S_MUL, S_OUT
	} state_t;

	typedef struct packed {
		logic clr;      // clear one map and run length entry
		logic load;     // capture input item
		logic div_step; // one quotient bit
		logic scan;     // test one unit
		logic mark;     // set one unit
		logic fread;    // free lookup done
		logic fclr;     // clear one unit
		logic mul;      // offset product
		logic out_load; // load output register
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic cmd;
		logic div_done;
		logic need_big;  // need exceeds pool
		logic found;
		logic scan_end;
		logic mark_done;
		logic in_range;
		logic fclr_done;
	} stat_t;
endpackage

[rtl/bffa_ctrl.sv]
// controller state machine for the allocator
// depends on bffa_pkg
`timescale 1ns / 1ps
module bffa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_free,
	input  bffa_pkg::stat_t st,
	output bffa_pkg::cmd_t cmd
);
	import bffa_pkg::*;
	state_t state_q, nxt;

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= nxt;
	end

	// next state and commands
	always_comb begin
		nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) nxt = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (st.cmd == CMD_FREE) begin
					nxt = S_FRD;
				end else if (st.div_done) begin
					nxt = st.need_big ? S_MUL : S_SCAN;
				end else cmd.div_step = 1'b1;
			end
			S_FRD: begin
				cmd.fread = 1'b1;
				nxt = st.in_range ? S_FCLR : S_MUL;
			end
			S_SCAN: begin
				if (st.found) nxt = S_MARK;
				else if (st.scan_end) nxt = S_MUL;
				else cmd.scan = 1'b1;
			end
			S_MARK: begin
				if (st.mark_done) nxt = S_MUL;
				else cmd.mark = 1'b1;
			end
			S_FCLR: begin
				if (st.fclr_done) nxt = S_MUL;
				else cmd.fclr = 1'b1;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				nxt = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	// a free never runs the search
	a_free_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (st.cmd == CMD_ALLOC)) else $error("scan on free");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DIV)) else $error("load not followed by divide");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE)) else $error("output not back to idle");
endmodule

[rtl/bffa_dp.sv]
// datapath: bitmap and run length rams, divider, search and offset product
// also holds the generic ram used for both stores; depends on bffa_pkg
`timescale 1ns / 1ps
module bffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end
	assign rdata = rdata_q;
endmodule

module bffa_dp (
	input  logic clk,
	input  logic arst_n,
	input  bffa_pkg::cmd_t cmd,
	output bffa_pkg::stat_t st,
	input  logic [34:0] in_data,
	input  logic [16:0] unit_bytes,
	input  logic [10:0] units_in_use,
	output logic [1:0] res_status,
	output logic [9:0] res_start,
	output logic [10:0] res_run,
	output logic [25:0] res_offset
);
	import bffa_pkg::*;

	logic cmd_q;
	logic [9:0] blk_q;
	logic [24:0] rem_q;                  // dividend shift / remainder
	logic [24:0] quo_q;
	logic [4:0] dcnt_q;
	logic [16:0] unit_q;
	logic [10:0] pool_q;
	logic [11:0] need_q;
	logic [10:0] s_q, k_q;
	logic ph_q;                          // scan phase: read issued / data back
	logic [UW-1:0] clr_q;
	logic [1:0] status_q;
	logic [9:0] start_q;
	logic [10:0] run_q;
	logic [25:0] off_q;

	logic [16:0] eu;
	logic [10:0] ep;
	logic [17:0] trial;
	logic [24:0] rem_sh;
	logic [11:0] need_c;
	logic [11:0] pos;
	logic [11:0] mpos;
	logic blk_in_pool;
	logic map_we, map_wd, map_rd;
	logic [UW-1:0] map_wa;
	logic len_we;
	logic [10:0] len_wd, len_rd;
	logic [UW-1:0] len_wa;

	assign eu = (unit_bytes == 17'd0) ? 17'd1 : (unit_bytes > 17'd65536 ? 17'd65536 : unit_bytes);
	assign ep = (units_in_use > 11'(UNITS)) ? 11'(UNITS) : units_in_use;
	// restoring divide on dividend bits shifted in from quo_q top
	assign rem_sh = {rem_q[23:0], quo_q[24]};
	assign trial = {1'b0, rem_sh[16:0]} - {1'b0, unit_q};
	assign need_c = (quo_q[11:0] + {11'd0, rem_q != 25'd0} == 12'd0) ? 12'd1
		: quo_q[11:0] + {11'd0, rem_q != 25'd0};
	assign pos = {1'b0, s_q} + {1'b0, k_q};
	// marking counts k down from the run length
	assign mpos = pos - 12'd1;
	assign blk_in_pool = ({1'b0, blk_q} < pool_q);

	// status to the controller
	always_comb begin
		st.clr_done = (clr_q == UW'(UNITS - 1));
		st.cmd = cmd_q;
		st.div_done = (dcnt_q == 5'd25);
		st.need_big = (quo_q[24:11] != 14'd0) || (need_c > {1'b0, pool_q});
		st.found = (k_q == need_q[10:0]);
		st.scan_end = ({1'b0, s_q} + need_q > {1'b0, pool_q});
		st.mark_done = (k_q == 11'd0);
		st.in_range = blk_in_pool && (len_rd != 11'd0);
		st.fclr_done = (k_q == run_q) || (pos >= 12'(UNITS));
	end

	// occupancy map write port
	always_comb begin
		map_we = cmd.clr || cmd.mark || cmd.fclr;
		map_wd = cmd.mark;
		map_wa = pos[UW-1:0];
		if (cmd.clr) map_wa = clr_q;
		else if (cmd.mark) map_wa = mpos[UW-1:0];
	end

	// run length write port, a zero entry means no run starts there
	always_comb begin
		len_we = cmd.clr || cmd.mark || (cmd.fread && blk_in_pool);
		len_wd = cmd.mark ? need_q[10:0] : 11'd0;
		len_wa = blk_q;
		if (cmd.clr) len_wa = clr_q;
		else if (cmd.mark) len_wa = s_q[UW-1:0];
	end

	bffa_ram #(.WIDTH(1), .DEPTH(UNITS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
		.raddr(pos[UW-1:0]), .rdata(map_rd)
	);

	bffa_ram #(.WIDTH(11), .DEPTH(UNITS)) u_len (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
		.raddr(blk_q), .rdata(len_rd)
	);

	// clearing pass address after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + UW'(1);
	end

	// item and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_data[0];
			quo_q <= {1'b0, in_data[24:1]} + 25'(HEADER_BYTES);
			rem_q <= '0;
			dcnt_q <= '0;
			blk_q <= in_data[34:25];
			unit_q <= eu;
			pool_q <= ep;
			s_q <= '0;
			k_q <= '0;
			ph_q <= 1'b0;
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 5'd1;
			if (rem_sh >= {8'd0, unit_q}) begin
				rem_q <= {7'd0, trial};
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[23:0], 1'b0};
			end
		end
		if (st.div_done && cmd_q == CMD_ALLOC) need_q <= need_c;
		if (cmd.scan) begin
			// a read phase then a data phase per unit, skip past an occupied unit
			ph_q <= ~ph_q;
			if (ph_q) begin
				if (map_rd) begin
					s_q <= pos[10:0] + 11'd1;
					k_q <= '0;
				end else k_q <= k_q + 11'd1;
			end
		end
		if (cmd.mark) k_q <= k_q - 11'd1;
		if (cmd.fread) begin
			s_q <= {1'b0, blk_q};
			k_q <= '0;
			run_q <= len_rd;
		end
		if (cmd.fclr) k_q <= k_q + 11'd1;
		if (cmd.mul) begin
			if (cmd_q == CMD_FREE) begin
				start_q <= blk_q;
				off_q <= (status_q == ST_OK) ? 26'(blk_q * unit_q + HEADER_BYTES) : 26'd0;
				if (status_q != ST_OK) run_q <= '0;
			end else if (status_q == ST_OK) begin
				start_q <= s_q[9:0];
				run_q <= need_q[10:0];
				off_q <= 26'(s_q[9:0] * unit_q + HEADER_BYTES);
			end else begin
				start_q <= '0;
				run_q <= '0;
				off_q <= '0;
			end
		end
	end

	// status: nospace at load, ok when a run is claimed; a free gets ok or range by pool bounds
	always_ff @(posedge clk) begin
		if (cmd.load) status_q <= ST_NOSPACE;
		else if (cmd.mark) status_q <= ST_OK;
		else if (cmd.fread) status_q <= blk_in_pool ? ST_OK : ST_RANGE;
	end

	assign res_status = status_q;
	assign res_start = start_q;
	assign res_run = run_q;
	assign res_offset = off_q;
endmodule

[rtl/bitmap_first_fit_allocator_unit.sv]
// top level of the bitmap first-fit allocator
// depends on bffa_pkg, bffa_ctrl, bffa_dp
`timescale 1ns / 1ps
// usage:
// s_axis carries one command transaction: tdata {block_unit, size_bytes, command}.
// m_axis returns one result transaction per command:
// tdata {data_offset, run_units, start_unit, status}.
// apb writes unit_bytes at 0x0 and units_in_use at 0x4; the user must write them
// only while idle, which the block itself does not enforce.
// an allocate divides size plus header into units, then searches the bitmap
// first fit, testing at most units_in_use units, and marks the run it finds;
// a request too large for the pool skips the search. a free reads the run length
// at its unit and clears that run, if any; the search reads one unit at a time.
// one item is in work at a time; the next is accepted in the cycle after the
// result is loaded, and it is taken while that result still waits.
// after reset a clearing pass frees every unit and zeroes every
// run record with the input held off; registers load 64 / 1024.
// when the receiver stalls the result holds and new work stops at output.
module bitmap_first_fit_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // command, size_bytes, block_unit
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [55:0] m_axis_tdata,  // status, start_unit, run_units, data_offset
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bffa_pkg::*;

	cmd_t cmd;
	stat_t st;
	logic [16:0] unit_bytes_q;
	logic [10:0] units_q;
	logic [1:0] r_status;
	logic [9:0] r_start;
	logic [10:0] r_run;
	logic [25:0] r_off;
	logic ovalid_q;
	logic [48:0] odata_q;
	logic wr;

	// register file
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q <= 17'd64;
			units_q <= 11'd1024;
		end else if (wr) begin
			if (paddr[2] == REG_UNITS_IN_USE[0] && paddr[1:0] == 2'd0) units_q <= pwdata[10:0];
			else if (paddr == 3'd0) unit_bytes_q <= pwdata[16:0];
		end
	end
	always_comb begin
		case (paddr[2])
			1'b0: prdata = {15'd0, unit_bytes_q};
			default: prdata = {21'd0, units_q};
		endcase
	end

	bffa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_free(!ovalid_q || m_axis_tready), .st(st), .cmd(cmd)
	);

	bffa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .in_data(s_axis_tdata[34:0]),
		.unit_bytes(unit_bytes_q), .units_in_use(units_q),
		.res_status(r_status), .res_start(r_start), .res_run(r_run), .res_offset(r_off)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.out_load) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) odata_q <= {r_off, r_run, r_start, r_status};
	end
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, odata_q};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_axis_tready) |=> $stable(odata_q)) else $error("result changed");
	a_nooverwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ovalid_q || m_axis_tready)) else $error("result overwritten");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (odata_q[1:0] != 2'd3)) else $error("bad status");
endmodule
